>>> src/shk_pkg.sv
// Shared types and constants for the shake gesture detector.
package shk_pkg;

  localparam int ACCEL_W   = 16;
  localparam int TIME_W    = 32;
  localparam int LEVEL_W   = 15;
  localparam int MS_W      = 16;
  localparam int FRAC_W    = 10;
  localparam int BASE_W    = ACCEL_W + FRAC_W;   // Q16.10 baseline
  localparam int MOT_W     = BASE_W + 1;         // motion, one bit of headroom
  localparam int MUL_W     = MOT_W + 7;          // motion times tracking gain
  localparam int OBC_W     = 8;
  localparam int SETTLE_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int EV_W      = 2;

  // idle tracking gain, 0.08 as 82/1024
  localparam logic signed [7:0] TRACK_GAIN = 8'sd82;
  localparam logic [SETTLE_W-1:0] SETTLE_DONE = 2'd3;
  localparam logic [OBC_W-1:0]    OBC_MAX     = 8'd255;
  localparam logic [OBC_W-1:0]    OBC_FIRE    = 8'd2;

  // result codes
  localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EV_W-1:0] EV_LEFT  = 2'd1;
  localparam logic [EV_W-1:0] EV_RIGHT = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETURN_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_DIR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FIRE_ON_OUT  = 3'd6;

  // register reset values
  localparam logic [LEVEL_W-1:0] RST_START_LEVEL  = 15'd2048;
  localparam logic [LEVEL_W-1:0] RST_RETURN_LEVEL = 15'd819;
  localparam logic [LEVEL_W-1:0] RST_SETTLE_LEVEL = 15'd573;
  localparam logic [MS_W-1:0]    RST_WINDOW_MS    = 16'd650;
  localparam logic [MS_W-1:0]    RST_COOLDOWN_MS  = 16'd450;

  typedef struct packed {
    logic [LEVEL_W-1:0] start_level;
    logic [LEVEL_W-1:0] return_level;
    logic [LEVEL_W-1:0] settle_level;
    logic [MS_W-1:0]    window_ms;
    logic [MS_W-1:0]    cooldown_ms;
    logic               invert_direction;
    logic               fire_early;
  } shk_cfg_t;

endpackage

>>> src/shk_cfg_regs.sv
// Configuration register bank.
module shk_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [shk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shk_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  output shk_pkg::shk_cfg_t              cfg
);
  import shk_pkg::*;

  shk_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_level      <= RST_START_LEVEL;
      cfg_r.return_level     <= RST_RETURN_LEVEL;
      cfg_r.settle_level     <= RST_SETTLE_LEVEL;
      cfg_r.window_ms        <= RST_WINDOW_MS;
      cfg_r.cooldown_ms      <= RST_COOLDOWN_MS;
      cfg_r.invert_direction <= 1'b0;
      cfg_r.fire_early       <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_START_LEVEL:  cfg_r.start_level      <= cfg_wdata[LEVEL_W-1:0];
        REG_RETURN_LEVEL: cfg_r.return_level     <= cfg_wdata[LEVEL_W-1:0];
        REG_SETTLE_LEVEL: cfg_r.settle_level     <= cfg_wdata[LEVEL_W-1:0];
        REG_WINDOW_MS:    cfg_r.window_ms        <= cfg_wdata[MS_W-1:0];
        REG_COOLDOWN_MS:  cfg_r.cooldown_ms      <= cfg_wdata[MS_W-1:0];
        REG_INVERT_DIR:   cfg_r.invert_direction <= cfg_wdata[0];
        REG_FIRE_ON_OUT:  cfg_r.fire_early       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/shk_core.sv
// Detection state machine, baseline tracker and event decode for one sample.
module shk_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [shk_pkg::ACCEL_W-1:0]  accel_x,
  input  logic [shk_pkg::TIME_W-1:0]   time_ms,
  input  shk_pkg::shk_cfg_t            cfg,
  output logic [shk_pkg::EV_W-1:0]     shake_event
);
  import shk_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_OUT  = 2'd1,
    PH_RET  = 2'd2,
    PH_WAIT = 2'd3
  } phase_t;

  phase_t                     phase_r, phase_nxt, phase_a;
  logic signed [BASE_W-1:0]   baseline_r, baseline_nxt;
  logic                       bvalid_r, bvalid_nxt;
  logic                       axis_pos_r, axis_pos_nxt;
  logic                       dir_left_r, dir_left_nxt;
  logic [SETTLE_W-1:0]        settle_r, settle_nxt, settle_inc;
  logic [OBC_W-1:0]           obc_r, obc_nxt;
  logic [TIME_W-1:0]          start_r, start_nxt;
  logic [TIME_W-1:0]          last_fire_r, last_fire_nxt;

  logic signed [MOT_W-1:0]    ax_scaled, motion, neg_rt, pos_rt;
  logic [MOT_W-1:0]           mag, st_lvl, se_lvl;
  logic signed [MUL_W-1:0]    track_prod;
  logic signed [BASE_W-1:0]   base_track;
  logic                       m_pos, ge_st, le_se, timeout, cool_blk;
  logic [TIME_W-1:0]          since_start, since_fire;

  // motion in Q17.10 against the baseline
  assign ax_scaled = {accel_x[ACCEL_W-1], accel_x, {FRAC_W{1'b0}}};
  assign motion    = bvalid_r ? (ax_scaled - MOT_W'(baseline_r)) : '0;
  assign mag       = motion[MOT_W-1] ? MOT_W'(-motion) : MOT_W'(motion);
  assign m_pos     = !motion[MOT_W-1] && (motion != '0);

  assign st_lvl = {2'b00, cfg.start_level,  {FRAC_W{1'b0}}};
  assign se_lvl = {2'b00, cfg.settle_level, {FRAC_W{1'b0}}};
  assign pos_rt = {2'b00, cfg.return_level, {FRAC_W{1'b0}}};
  assign neg_rt = -pos_rt;
  assign ge_st  = mag >= st_lvl;
  assign le_se  = mag <= se_lvl;

  // arithmetic shift of the product floors toward minus infinity
  assign track_prod = MUL_W'(motion) * MUL_W'(TRACK_GAIN);
  assign base_track = baseline_r + BASE_W'(track_prod >>> FRAC_W);

  assign since_start = time_ms - start_r;
  assign since_fire  = time_ms - last_fire_r;
  assign timeout     = since_start > {{(TIME_W-MS_W){1'b0}}, cfg.window_ms};
  assign cool_blk    = since_fire < {{(TIME_W-MS_W){1'b0}}, cfg.cooldown_ms};

  always_comb begin
    baseline_nxt  = baseline_r;
    bvalid_nxt    = bvalid_r;
    axis_pos_nxt  = axis_pos_r;
    dir_left_nxt  = dir_left_r;
    settle_nxt    = settle_r;
    obc_nxt       = obc_r;
    start_nxt     = start_r;
    last_fire_nxt = last_fire_r;
    shake_event   = EV_NONE;
    phase_a       = phase_r;

    if ((phase_r == PH_OUT || phase_r == PH_RET) && timeout) begin
      phase_a      = PH_IDLE;
      axis_pos_nxt = 1'b0;
      dir_left_nxt = 1'b0;
      settle_nxt   = '0;
      obc_nxt      = '0;
    end
    phase_nxt  = phase_a;
    settle_inc = settle_nxt + 1'b1;

    if (!bvalid_r) begin
      baseline_nxt = ax_scaled[BASE_W-1:0];
      bvalid_nxt   = 1'b1;
    end else begin
      unique case (phase_a)
        PH_WAIT: begin
          if (le_se) begin
            if (settle_inc == SETTLE_DONE) begin
              phase_nxt    = PH_IDLE;
              axis_pos_nxt = 1'b0;
              dir_left_nxt = 1'b0;
              settle_nxt   = '0;
              obc_nxt      = '0;
            end else begin
              settle_nxt = settle_inc;
            end
          end else begin
            settle_nxt = '0;
          end
        end
        PH_IDLE: begin
          if (!ge_st) begin
            baseline_nxt = base_track;
          end else if (!cool_blk) begin
            axis_pos_nxt = m_pos;
            dir_left_nxt = m_pos ^ cfg.invert_direction;
            start_nxt    = time_ms;
            phase_nxt    = PH_OUT;
            obc_nxt      = OBC_W'(1);
          end
        end
        PH_OUT: begin
          if (ge_st && (m_pos == axis_pos_r)) begin
            if (obc_r != OBC_MAX) obc_nxt = obc_r + 1'b1;
          end else begin
            obc_nxt = '0;
          end
          if (cfg.fire_early && (obc_nxt >= OBC_FIRE)) begin
            shake_event   = dir_left_r ? EV_LEFT : EV_RIGHT;
            last_fire_nxt = time_ms;
            phase_nxt     = PH_WAIT;
            axis_pos_nxt  = 1'b0;
            dir_left_nxt  = 1'b0;
            settle_nxt    = '0;
            obc_nxt       = '0;
          end else if ((axis_pos_r && (motion <= neg_rt)) ||
                       (!axis_pos_r && (motion >= pos_rt))) begin
            phase_nxt  = PH_RET;
            settle_nxt = '0;
          end
        end
        PH_RET: begin
          if (le_se) begin
            if (settle_inc == SETTLE_DONE) begin
              shake_event   = dir_left_r ? EV_LEFT : EV_RIGHT;
              last_fire_nxt = time_ms;
              phase_nxt     = PH_IDLE;
              axis_pos_nxt  = 1'b0;
              dir_left_nxt  = 1'b0;
              settle_nxt    = '0;
            end else begin
              settle_nxt = settle_inc;
            end
          end else begin
            settle_nxt = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      baseline_r  <= '0;
      bvalid_r    <= 1'b0;
      axis_pos_r  <= 1'b0;
      dir_left_r  <= 1'b0;
      settle_r    <= '0;
      obc_r       <= '0;
      start_r     <= '0;
      last_fire_r <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      baseline_r  <= baseline_nxt;
      bvalid_r    <= bvalid_nxt;
      axis_pos_r  <= axis_pos_nxt;
      dir_left_r  <= dir_left_nxt;
      settle_r    <= settle_nxt;
      obc_r       <= obc_nxt;
      start_r     <= start_nxt;
      last_fire_r <= last_fire_nxt;
    end
  end

  // no shake can be under way before the first sample sets the baseline
  a_idle_until_baseline: assert property (@(posedge clk) disable iff (!rst_n)
    !bvalid_r |-> phase_r == PH_IDLE)
    else $error("phase left idle without a baseline");

  // a settle count of three is always consumed in the same item
  a_settle_never_done: assert property (@(posedge clk) disable iff (!rst_n)
    settle_r != SETTLE_DONE)
    else $error("settle count held at its terminal value");

  a_fire_stamps_time: assert property (@(posedge clk) disable iff (!rst_n)
    step && shake_event != EV_NONE |=> last_fire_r == $past(time_ms))
    else $error("fired without recording the fire time");

  a_fire_phase: assert property (@(posedge clk) disable iff (!rst_n)
    step && shake_event != EV_NONE |=> phase_r == PH_IDLE || phase_r == PH_WAIT)
    else $error("fired into an active phase");

endmodule

>>> src/shake_gesture_detector.sv
// An accepted item waits in the input register until the output register is
// free or read, is then evaluated against the detector state, and its result
// is registered at the output. Throughput: one item per cycle while out_ready
// holds; the whole state update (baseline, phase, counters, timestamps) is one
// combinational pass. Reset (rst_n, synchronous): both stages empty, detector
// idle with no baseline, config and detector state back to their reset values.
module shake_gesture_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [shk_pkg::ACCEL_W-1:0] in_accel_x,
  input  logic [shk_pkg::TIME_W-1:0]     in_time_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [shk_pkg::EV_W-1:0]       out_shake_event,
  input  logic                           cfg_wr_en,
  input  logic [shk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shk_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import shk_pkg::*;

  shk_cfg_t           cfg;
  logic               in_vld_r, out_vld_r, advance;
  logic [ACCEL_W-1:0] accel_r;
  logic [TIME_W-1:0]  time_r;
  logic [EV_W-1:0]    ev, ev_r;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  shk_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  shk_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .accel_x     (accel_r),
    .time_ms     (time_r),
    .cfg         (cfg),
    .shake_event (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      if (!out_vld_r || out_ready) out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      accel_r <= in_accel_x;
      time_r  <= in_time_ms;
    end
    if (advance) ev_r <= ev;
  end

  assign out_valid       = out_vld_r;
  assign out_shake_event = ev_r;

endmodule

>>> test/testbench.sv
// Self-checking testbench for the shake gesture detector: directed cases, then random gestures.
`timescale 1ns / 100ps

module testbench;
  import shk_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int MAX_REPORTS = 30;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;    // past the last register
  localparam logic signed [7:0] TRACK_NUM = 8'sd82;    // 0.08 as 82/1024
  localparam logic [OBC_W-1:0] OBC_SAT = 8'd255;
  localparam logic [SETTLE_W-1:0] SETTLE_SAMPLES = 2'd3;

  typedef enum logic [1:0] {PH_IDLE, PH_OUT, PH_RET, PH_WAIT} det_phase_t;

  typedef struct {
    logic [EV_W-1:0] ev;
    int unsigned     item_no;
  } shake_exp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [ACCEL_W-1:0] in_accel_x = '0;
  logic [TIME_W-1:0] in_time_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [EV_W-1:0] out_shake_event;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  shake_gesture_detector dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_accel_x(in_accel_x), .in_time_ms(in_time_ms),
    .out_valid(out_valid), .out_ready(out_ready), .out_shake_event(out_shake_event),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // detector model state
  shk_cfg_t                 cfg_model;
  det_phase_t               det_phase;
  logic signed [BASE_W-1:0] base_q10;
  logic                     base_valid;
  logic                     axis_pos;
  logic                     dir_left;
  logic [SETTLE_W-1:0]      settle_cnt;
  logic [OBC_W-1:0]         out_cnt;
  logic [TIME_W-1:0]        start_ms;
  logic [TIME_W-1:0]        last_fire_ms;

  shake_exp_t  expected_events[$];
  logic [TIME_W-1:0] now_ms = '0;
  int unsigned items_sent = 0;
  int unsigned checked = 0;
  int unsigned left_seen = 0;
  int unsigned right_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             expected_events.size());
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic reset_model();
    cfg_model.start_level      = RST_START_LEVEL;
    cfg_model.return_level     = RST_RETURN_LEVEL;
    cfg_model.settle_level     = RST_SETTLE_LEVEL;
    cfg_model.window_ms        = RST_WINDOW_MS;
    cfg_model.cooldown_ms      = RST_COOLDOWN_MS;
    cfg_model.invert_direction = 1'b0;
    cfg_model.fire_early       = 1'b1;
    det_phase = PH_IDLE;
    base_q10 = '0;
    base_valid = 1'b0;
    clear_motion();
    start_ms = '0;
    last_fire_ms = '0;
  endtask

  function automatic void clear_motion();
    axis_pos = 1'b0;
    dir_left = 1'b0;
    settle_cnt = '0;
    out_cnt = '0;
  endfunction

  function automatic void model_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] data);
    case (idx)
      REG_START_LEVEL:  cfg_model.start_level = data[LEVEL_W-1:0];
      REG_RETURN_LEVEL: cfg_model.return_level = data[LEVEL_W-1:0];
      REG_SETTLE_LEVEL: cfg_model.settle_level = data[LEVEL_W-1:0];
      REG_WINDOW_MS:    cfg_model.window_ms = data[MS_W-1:0];
      REG_COOLDOWN_MS:  cfg_model.cooldown_ms = data[MS_W-1:0];
      REG_INVERT_DIR:   cfg_model.invert_direction = data[0];
      REG_FIRE_ON_OUT:  cfg_model.fire_early = data[0];
      default: ;
    endcase
  endfunction

  // Advances the detector model by one sample and returns the shake it reports.
  function automatic logic [EV_W-1:0] predict_shake(input logic signed [ACCEL_W-1:0] ax,
                                                    input logic [TIME_W-1:0] now);
    logic signed [MOT_W-1:0] ax_q, base_x, m, am, st_s, rt_s, se_s;
    logic signed [MUL_W-1:0] prod;
    logic [TIME_W-1:0] dt;
    logic [EV_W-1:0] ev;
    ax_q = ax;
    ax_q = ax_q <<< FRAC_W;
    base_x = base_q10;
    m = base_valid ? ax_q - base_x : '0;
    am = (m < 0) ? -m : m;
    st_s = {2'b00, cfg_model.start_level, {FRAC_W{1'b0}}};
    rt_s = {2'b00, cfg_model.return_level, {FRAC_W{1'b0}}};
    se_s = {2'b00, cfg_model.settle_level, {FRAC_W{1'b0}}};
    ev = dir_left ? EV_LEFT : EV_RIGHT;

    dt = now - start_ms;
    if ((det_phase == PH_OUT || det_phase == PH_RET) && dt > TIME_W'(cfg_model.window_ms)) begin
      det_phase = PH_IDLE;
      clear_motion();
    end

    if (!base_valid) begin
      base_q10 = ax_q[BASE_W-1:0];
      base_valid = 1'b1;
      return EV_NONE;
    end

    case (det_phase)
      PH_WAIT: begin
        if (am <= se_s) begin
          settle_cnt++;
          if (settle_cnt >= SETTLE_SAMPLES) begin
            det_phase = PH_IDLE;
            clear_motion();
          end
        end else begin
          settle_cnt = '0;
        end
        return EV_NONE;
      end
      PH_IDLE: begin
        if (am < st_s) begin
          prod = m * TRACK_NUM;
          base_q10 = base_q10 + BASE_W'(prod >>> FRAC_W);
          return EV_NONE;
        end
        dt = now - last_fire_ms;
        if (dt < TIME_W'(cfg_model.cooldown_ms)) return EV_NONE;
        axis_pos = (m > 0);
        dir_left = (axis_pos == !cfg_model.invert_direction);
        start_ms = now;
        det_phase = PH_OUT;
        out_cnt = 8'd1;
        return EV_NONE;
      end
      PH_OUT: begin
        if (am >= st_s && ((m > 0) == axis_pos)) begin
          if (out_cnt < OBC_SAT) out_cnt++;
        end else begin
          out_cnt = '0;
        end
        if (cfg_model.fire_early && out_cnt >= 8'd2) begin
          last_fire_ms = now;
          det_phase = PH_WAIT;
          clear_motion();
          return ev;
        end
        if ((axis_pos && m <= -rt_s) || (!axis_pos && m >= rt_s)) begin
          det_phase = PH_RET;
          settle_cnt = '0;
        end
        return EV_NONE;
      end
      default: begin
        if (am <= se_s) begin
          settle_cnt++;
          if (settle_cnt < SETTLE_SAMPLES) return EV_NONE;
          last_fire_ms = now;
          det_phase = PH_IDLE;
          axis_pos = 1'b0;
          dir_left = 1'b0;
          settle_cnt = '0;
          return ev;
        end
        settle_cnt = '0;
        return EV_NONE;
      end
    endcase
  endfunction

  // Sample at a given offset (1/4096 g) from the current model baseline, clamped.
  function automatic logic signed [ACCEL_W-1:0] near_baseline(input int off);
    int v;
    v = int'(base_q10 >>> FRAC_W) + off;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[ACCEL_W-1:0];
  endfunction

  function automatic int spread(input int a);
    return int'($urandom_range(0, 2 * a)) - a;
  endfunction

  function automatic logic [TIME_W-1:0] pick_dt();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 90) return $urandom_range(1, 60);
    if (r < 98) return $urandom_range(100, 1000);
    return $urandom;
  endfunction

  task automatic send_sample(input logic signed [ACCEL_W-1:0] ax, input logic [TIME_W-1:0] dt);
    shake_exp_t e;
    now_ms = now_ms + dt;
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_accel_x <= ax;
    in_time_ms <= now_ms;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    e.ev = predict_shake(ax, now_ms);
    e.item_no = items_sent;
    expected_events.push_back(e);
  endtask

  // Lets every pending result come back so registers can be written.
  task automatic quiesce();
    int n;
    @(negedge clk);
    in_valid <= 1'b0;
    n = 0;
    while (expected_events.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (expected_events.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived, oldest item %0d",
                                expected_events.size(), expected_events[0].item_no));
      expected_events.delete();
    end
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    model_write(idx, data);
    reg_writes++;
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("result %0d with no item pending", out_shake_event));
      end else begin
        if (out_shake_event !== expected_events[0].ev)
          report_mismatch($sformatf("item %0d: shake_event %0d, expected %0d",
                                    expected_events[0].item_no, out_shake_event,
                                    expected_events[0].ev));
        if (expected_events[0].ev == EV_LEFT) left_seen++;
        if (expected_events[0].ev == EV_RIGHT) right_seen++;
        checked++;
        void'(expected_events.pop_front());
      end
    end
  end

  // First sample sets the baseline; starts are blocked until the cooldown after reset.
  task automatic test_first_sample_and_cooldown();
    now_ms = '0;
    send_sample(-16'sd32768, 0);
    send_sample(16'sd32767, 0);
    send_sample(16'sd32767, 449);
    now_ms = 32'hFFFF_FFFF;
    send_sample(16'sd0, 0);            // starts, time at its top
    send_sample(16'sd32767, 6);        // wraps to 5, fires left
    repeat (3) send_sample(-16'sd32768, 5);
  endtask

  // Baseline is still exact here, so the samples below give zero motion.
  task automatic test_zero_levels();
    quiesce();
    write_reg(REG_START_LEVEL, 16'd0);
    write_reg(REG_RETURN_LEVEL, 16'd0);
    write_reg(REG_SETTLE_LEVEL, 16'd0);
    write_reg(REG_COOLDOWN_MS, 16'd0);
    repeat (5) send_sample(-16'sd32768, 10);
    quiesce();
    write_reg(REG_FIRE_ON_OUT, 16'd0);
    repeat (5) send_sample(-16'sd32768, 10);   // start, returning at once, settle
    quiesce();
    write_reg(REG_START_LEVEL, 16'(RST_START_LEVEL));
    write_reg(REG_RETURN_LEVEL, 16'(RST_RETURN_LEVEL));
    write_reg(REG_SETTLE_LEVEL, 16'(RST_SETTLE_LEVEL));
    write_reg(REG_COOLDOWN_MS, RST_COOLDOWN_MS);
    write_reg(REG_FIRE_ON_OUT, 16'd1);
  endtask

  // Bits above a register's width and an unused index must have no effect.
  task automatic test_register_writes();
    quiesce();
    write_reg(REG_START_LEVEL, 16'h8000 | 16'(RST_START_LEVEL));
    write_reg(REG_RETURN_LEVEL, 16'hFFFF);
    write_reg(REG_SETTLE_LEVEL, 16'h8000 | 16'(RST_SETTLE_LEVEL));
    write_reg(REG_INVERT_DIR, 16'hFFFE);
    write_reg(REG_FIRE_ON_OUT, 16'hFFFF);
    write_reg(REG_NONE, 16'h0000);
    send_sample(near_baseline(0), 20);
    send_sample(near_baseline(1500), 20);
    send_sample(near_baseline(2500), 500);
    send_sample(near_baseline(2500), 20);
    repeat (3) send_sample(near_baseline(0), 20);
    quiesce();
    write_reg(REG_RETURN_LEVEL, 16'(RST_RETURN_LEVEL));
  endtask

  // Full gestures both ways, with and without inversion, and wait-neutral behavior.
  task automatic test_gestures();
    quiesce();
    write_reg(REG_INVERT_DIR, 16'd1);
    write_reg(REG_FIRE_ON_OUT, 16'd0);
    send_sample(near_baseline(0), 600);
    send_sample(near_baseline(3000), 20);
    send_sample(near_baseline(3000), 20);
    send_sample(near_baseline(-1000), 20);
    repeat (3) send_sample(near_baseline(0), 20);
    send_sample(near_baseline(-2500), 500);
    send_sample(near_baseline(900), 20);
    send_sample(near_baseline(300), 20);
    send_sample(near_baseline(800), 20);       // breaks the settle run
    repeat (3) send_sample(near_baseline(0), 20);
    quiesce();
    write_reg(REG_INVERT_DIR, 16'd0);
    write_reg(REG_FIRE_ON_OUT, 16'd1);
    send_sample(near_baseline(-3000), 500);
    send_sample(near_baseline(-3000), 20);
    send_sample(near_baseline(5000), 2000);    // no timeout while waiting neutral
    repeat (3) send_sample(near_baseline(0), 20);
  endtask

  task automatic test_timeout();
    quiesce();
    write_reg(REG_WINDOW_MS, 16'd100);
    write_reg(REG_FIRE_ON_OUT, 16'd0);
    send_sample(near_baseline(3000), 600);
    send_sample(near_baseline(3000), 101);     // times out, then restarts
    send_sample(near_baseline(-1500), 50);
    send_sample(near_baseline(0), 60);         // times out while returning
    repeat (2) send_sample(near_baseline(0), 10);
    now_ms = 32'hFFFF_FFC0;
    send_sample(near_baseline(3000), 0);
    send_sample(near_baseline(-1500), 80);
    repeat (3) send_sample(near_baseline(0), 5);
    quiesce();
    write_reg(REG_WINDOW_MS, RST_WINDOW_MS);
  endtask

  // 255 outbound samples, then one more with fire-on-outbound: a wrapped count would not fire.
  task automatic test_outbound_saturation();
    quiesce();
    write_reg(REG_FIRE_ON_OUT, 16'd0);
    write_reg(REG_WINDOW_MS, 16'hFFFF);
    write_reg(REG_COOLDOWN_MS, 16'd0);
    send_sample(near_baseline(0), 1000);
    repeat (255) send_sample(near_baseline(3000), 0);
    quiesce();
    write_reg(REG_FIRE_ON_OUT, 16'd1);
    send_sample(near_baseline(3000), 0);
    repeat (3) send_sample(near_baseline(0), 10);
    quiesce();
    write_reg(REG_WINDOW_MS, RST_WINDOW_MS);
    write_reg(REG_COOLDOWN_MS, RST_COOLDOWN_MS);
  endtask

  task automatic load_random_config(input int mode);
    case (mode)
      0: begin
        write_reg(REG_START_LEVEL, 16'd0);
        write_reg(REG_RETURN_LEVEL, 16'd0);
        write_reg(REG_SETTLE_LEVEL, 16'd0);
        write_reg(REG_WINDOW_MS, 16'd0);
        write_reg(REG_COOLDOWN_MS, 16'd0);
      end
      1: begin
        write_reg(REG_START_LEVEL, 16'd32767);
        write_reg(REG_RETURN_LEVEL, 16'd32767);
        write_reg(REG_SETTLE_LEVEL, 16'd32767);
        write_reg(REG_WINDOW_MS, 16'hFFFF);
        write_reg(REG_COOLDOWN_MS, 16'hFFFF);
      end
      default: begin
        write_reg(REG_START_LEVEL, 16'($urandom_range(300, 4000)));
        write_reg(REG_RETURN_LEVEL, 16'($urandom_range(100, 2500)));
        write_reg(REG_SETTLE_LEVEL, 16'($urandom_range(50, 1200)));
        write_reg(REG_WINDOW_MS, 16'($urandom_range(50, 1500)));
        write_reg(REG_COOLDOWN_MS, 16'($urandom_range(0, 800)));
      end
    endcase
    write_reg(REG_INVERT_DIR, 16'($urandom));
    write_reg(REG_FIRE_ON_OUT, 16'($urandom));
  endtask

  // Mostly well-formed gestures around the tracked baseline, some noise and long pauses.
  task automatic run_traffic(input int n);
    int sent, kind, s, st, rt, se;
    sent = 0;
    while (sent < n) begin
      st = int'(cfg_model.start_level);
      rt = int'(cfg_model.return_level);
      se = int'(cfg_model.settle_level);
      kind = $urandom_range(0, 99);
      s = $urandom_range(0, 1) ? 1 : -1;
      if (kind < 70) begin
        repeat ($urandom_range(0, 3)) begin
          send_sample(near_baseline(spread(st / 2)), pick_dt());
          sent++;
        end
        repeat ($urandom_range(1, 4)) begin
          send_sample(near_baseline(s * (st + int'($urandom_range(0, 2500)))), pick_dt());
          sent++;
        end
        repeat ($urandom_range(0, 2)) begin
          send_sample(near_baseline(-s * (rt + int'($urandom_range(0, 1500)))), pick_dt());
          sent++;
        end
        repeat ($urandom_range(1, 4)) begin
          send_sample(near_baseline(spread(se)), pick_dt());
          sent++;
        end
      end else if (kind < 85) begin
        send_sample(16'($urandom), pick_dt());
        sent++;
      end else begin
        send_sample(near_baseline(spread(se)), $urandom_range(300, 3000));
        sent++;
      end
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 61; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 61; end
        default: begin in_idle_pct = 8; out_stall_pct = 8; end
      endcase
      now_ms = $urandom;
      for (int b = 0; b < 3; b++) begin
        quiesce();
        if (b == 0 && p == 1) load_random_config(0);
        else if (b == 0 && p == 2) load_random_config(1);
        else load_random_config(2);
        run_traffic(100);
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_first_sample_and_cooldown();
    test_zero_levels();
    test_register_writes();
    test_gestures();
    test_timeout();
    test_outbound_saturation();
    test_random();
    quiesce();
    repeat (20) @(posedge clk);
    $display("summary: %0d items sent, %0d results checked (%0d left, %0d right shakes)",
             items_sent, checked, left_seen, right_seen);
    $display("summary: %0d register writes over directed cases and four idle/stall mixes",
             reg_writes);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
src/shk_pkg.sv
src/shk_cfg_regs.sv
src/shk_core.sv
src/shake_gesture_detector.sv
test/testbench.sv
